// ----- hw/rtl/vpe_capability_selector_table_core_macros.svh -----
// ----------------------------------------------------------------------------
// VPE capability selector table - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef VPE_CAPABILITY_SELECTOR_TABLE_CORE_MACROS_SVH
`define VPE_CAPABILITY_SELECTOR_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define VCST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define VCST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/vcst_pkg.sv -----
// ----------------------------------------------------------------------------
// vcst_pkg - VPE capability selector table package
// Operation and status codes, FSM states, slot record type and defaults.
// ----------------------------------------------------------------------------
package vcst_pkg;

  // default sizing
  localparam int DEF_VPE_SLOTS         = 8;
  localparam int DEF_SELECTORS_PER_VPE = 32;

  // payload widths
  localparam int FUNC_W   = 3;
  localparam int ID_W     = 16;
  localparam int KIND_W   = 2;
  localparam int SELIN_W  = 8;
  localparam int CAP_W    = 64;
  localparam int STATUS_W = 2;
  localparam int SLOTO_W  = 3;
  localparam int SELO_W   = 6;
  localparam int COUNT_W  = 4;

  // id that never matches a slot
  localparam logic [ID_W-1:0]  NO_ID        = 16'hFFFF;
  // selector entry marked reserved by alloc
  localparam logic [CAP_W-1:0] SEL_RESERVED = {CAP_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE  = 3'd0,
    FN_FIND    = 3'd1,
    FN_DESTROY = 3'd2,
    FN_CLEAR   = 3'd3,
    FN_BIND    = 3'd4,
    FN_LOOKUP  = 3'd5,
    FN_UNBIND  = 3'd6,
    FN_ALLOC   = 3'd7
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_SPACE  = 2'd2,
    STAT_BAD_SEL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_WALK,
    S_LOOK,
    S_FINAL
  } state_t;

  // per-slot record held in the slot RAM
  typedef struct packed {
    logic [KIND_W-1:0] vpe_kind;
    logic [ID_W-1:0]   kernel_id;
    logic [ID_W-1:0]   vpe_id;
  } meta_t;

endpackage

// ----- hw/rtl/vcst_if.sv -----
// ----------------------------------------------------------------------------
// vcst_if - request and response channels
// Valid/ready channels carrying one operation beat and one result beat.
// ----------------------------------------------------------------------------
interface vcst_req_if;
  logic                         valid;
  logic                         ready;
  logic [vcst_pkg::FUNC_W-1:0]  func;
  logic [vcst_pkg::ID_W-1:0]    vpe_id;
  logic [vcst_pkg::ID_W-1:0]    kernel_id;
  logic [vcst_pkg::KIND_W-1:0]  vpe_kind;
  logic [vcst_pkg::SELIN_W-1:0] selector;
  logic [vcst_pkg::CAP_W-1:0]   cap_value;

  modport source (output valid, func, vpe_id, kernel_id, vpe_kind, selector, cap_value,
                  input ready);
  modport sink   (input valid, func, vpe_id, kernel_id, vpe_kind, selector, cap_value,
                  output ready);
endinterface

interface vcst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vcst_pkg::STATUS_W-1:0] status;
  logic [vcst_pkg::SLOTO_W-1:0]  slot_index;
  logic [vcst_pkg::SELO_W-1:0]   selector_out;
  logic [vcst_pkg::CAP_W-1:0]    cap_out;
  logic                          revoke;
  logic [vcst_pkg::COUNT_W-1:0]  vpe_count;
  logic                          last;

  modport source (output valid, status, slot_index, selector_out, cap_out, revoke,
                  vpe_count, last, input ready);
  modport sink   (input valid, status, slot_index, selector_out, cap_out, revoke,
                  vpe_count, last, output ready);
endinterface

// ----- hw/rtl/vcst_ram.sv -----
// ----------------------------------------------------------------------------
// vcst_ram - generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vcst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/vpe_capability_selector_table_core.sv -----
// ----------------------------------------------------------------------------
// vpe_capability_selector_table_core - VPE registry with selector tables
// Slot records and selector tables live in two RAMs driven by one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation beat (func, vpe_id, kernel_id, vpe_kind,
//   selector, cap_value); rsp returns result beats, the final one with last.
//   Clear and destroy return one revoke beat per non-empty selector first.
//   One operation is in flight at a time; req.ready is high only when idle.
// Sequencing:
//   Slot lookup reads the slot RAM one record per cycle and stops at the
//   match. Then find/create/bind/unbind answer from S_EXEC, lookup reads the
//   entry and answers from S_LOOK, alloc walks selectors until a free one,
//   clear and destroy walk every selector, all paced by the single selector
//   RAM read port.
// Reset:
//   rst clears the slot flags and the live count, then the selector RAM is
//   swept to zero, one entry per cycle, before req.ready rises.
// Stall:
//   Results sit in an output register; if full and rsp.ready low, emits hold.
// ----------------------------------------------------------------------------
module vpe_capability_selector_table_core #(
  parameter int VPE_SLOTS         = vcst_pkg::DEF_VPE_SLOTS,
  parameter int SELECTORS_PER_VPE = vcst_pkg::DEF_SELECTORS_PER_VPE
) (
  input  logic       clk,
  input  logic       rst,
  vcst_req_if.sink   req,
  vcst_rsp_if.source rsp
);

  localparam int SLOT_W = (VPE_SLOTS > 1) ? $clog2(VPE_SLOTS) : 1;
  localparam int SLOT_N = 1 << SLOT_W;
  localparam int SEL_W  = $clog2(SELECTORS_PER_VPE);
  localparam int SA_W   = SLOT_W + SEL_W;
  localparam int SA_N   = 1 << SA_W;
  localparam int CNT_W  = $clog2(VPE_SLOTS + 1);
  localparam int META_W = $bits(vcst_pkg::meta_t);

  localparam logic [SLOT_W:0]   SLOT_CNT  = (SLOT_W+1)'(VPE_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(VPE_SLOTS - 1);
  localparam logic [SEL_W:0]    SEL_CNT   = (SEL_W+1)'(SELECTORS_PER_VPE);
  localparam logic [SEL_W-1:0]  SEL_LAST  = SEL_W'(SELECTORS_PER_VPE - 1);
  localparam logic [vcst_pkg::SELIN_W-1:0] SEL_LIM = vcst_pkg::SELIN_W'(SELECTORS_PER_VPE);

  // control state
  vcst_pkg::state_t   state, state_next;
  logic [SLOT_N-1:0]  slot_live;
  logic [CNT_W-1:0]   live_count;
  logic [SA_W-1:0]    clr_addr;
  logic               out_valid;

  // operation registers
  vcst_pkg::func_t              op_func;
  logic [vcst_pkg::ID_W-1:0]    op_id;
  logic [vcst_pkg::ID_W-1:0]    op_kid;
  logic [vcst_pkg::KIND_W-1:0]  op_kind;
  logic [vcst_pkg::SELIN_W-1:0] op_sel;
  logic [vcst_pkg::CAP_W-1:0]   op_cap;

  // slot scan
  logic [SLOT_W:0]   scan_idx;
  logic              cmp_pend;
  logic [SLOT_W-1:0] cmp_idx;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              free_ok;
  logic [SLOT_W-1:0] free_idx;

  // selector walk
  logic [SEL_W:0]   walk_sel;
  logic             wcmp_pend;
  logic [SEL_W-1:0] wcmp_sel;

  // output register
  vcst_pkg::status_t             out_status;
  logic [vcst_pkg::SLOTO_W-1:0]  out_slot;
  logic [vcst_pkg::SELO_W-1:0]   out_sel;
  logic [vcst_pkg::CAP_W-1:0]    out_cap;
  logic                          out_revoke;
  logic [vcst_pkg::COUNT_W-1:0]  out_count;
  logic                          out_last;

  // RAM ports
  vcst_pkg::meta_t    meta_rd;
  logic               meta_re;
  logic               meta_we;
  logic [SLOT_W-1:0]  meta_raddr;
  logic               sel_we;
  logic               sel_re;
  logic [SA_W-1:0]    sel_waddr;
  logic [SA_W-1:0]    sel_raddr;
  logic [vcst_pkg::CAP_W-1:0] sel_wdata;
  logic [vcst_pkg::CAP_W-1:0] sel_rdata;

  // sequencer strobes
  logic                       req_ready;
  logic                       accept;
  logic                       out_free;
  logic                       emit;
  vcst_pkg::status_t          e_status;
  logic [SLOT_W-1:0]          e_slot;
  logic [SEL_W-1:0]           e_sel;
  logic [vcst_pkg::CAP_W-1:0] e_cap;
  logic                       e_revoke;
  logic                       e_last;
  logic [CNT_W-1:0]           e_count;
  logic                       scan_step;
  logic                       scan_issue;
  logic                       cmp_match;
  logic                       walk_start;
  logic                       walk_adv;
  logic                       walk_issue;
  logic                       live_set;
  logic                       live_clr;
  logic                       count_upd;
  logic [CNT_W-1:0]           count_val;
  logic [CNT_W-1:0]           count_dec;
  logic [CNT_W-1:0]           count_after;
  logic                       revoke_walk;
  logic                       sel_nz;
  logic                       sel_ok;

  vcst_ram #(.WIDTH(META_W), .DEPTH(SLOT_N)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (free_idx),
    .wdata ({op_kind, op_kid, op_id}),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rd)
  );

  vcst_ram #(.WIDTH(vcst_pkg::CAP_W), .DEPTH(SA_N)) u_sel_ram (
    .clk   (clk),
    .we    (sel_we),
    .waddr (sel_waddr),
    .wdata (sel_wdata),
    .re    (sel_re),
    .raddr (sel_raddr),
    .rdata (sel_rdata)
  );

  assign accept      = req.valid && req_ready;
  assign req.ready   = req_ready;
  assign out_free    = !out_valid || rsp.ready;
  assign count_dec   = (live_count != '0) ? live_count - CNT_W'(1) : live_count;
  assign count_after = (op_func == vcst_pkg::FN_DESTROY) ? count_dec : live_count;
  assign revoke_walk = (op_func == vcst_pkg::FN_CLEAR) || (op_func == vcst_pkg::FN_DESTROY);
  assign sel_nz      = (sel_rdata != '0);
  assign sel_ok      = (op_sel < SEL_LIM);
  assign scan_step   = (state == vcst_pkg::S_SCAN) && (op_id != vcst_pkg::NO_ID);
  assign cmp_match   = cmp_pend && slot_live[cmp_idx] && (meta_rd.vpe_id == op_id);

  // next state and strobes
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    emit       = 1'b0;
    e_status   = vcst_pkg::STAT_OK;
    e_slot     = '0;
    e_sel      = '0;
    e_cap      = '0;
    e_revoke   = 1'b0;
    e_last     = 1'b1;
    e_count    = live_count;
    meta_re    = 1'b0;
    meta_we    = 1'b0;
    meta_raddr = scan_idx[SLOT_W-1:0];
    sel_re     = 1'b0;
    sel_raddr  = {hit_idx, walk_sel[SEL_W-1:0]};
    sel_we     = 1'b0;
    sel_waddr  = {hit_idx, wcmp_sel};
    sel_wdata  = '0;
    scan_issue = 1'b0;
    walk_start = 1'b0;
    walk_adv   = 1'b0;
    walk_issue = 1'b0;
    live_set   = 1'b0;
    live_clr   = 1'b0;
    count_upd  = 1'b0;
    count_val  = live_count;

    case (state)
      // zero the selector RAM after reset
      vcst_pkg::S_INIT: begin
        sel_we    = 1'b1;
        sel_waddr = clr_addr;
        if (&clr_addr) begin
          state_next = vcst_pkg::S_IDLE;
        end
      end

      vcst_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (accept) begin
          state_next = vcst_pkg::S_SCAN;
        end
      end

      // one slot record read per cycle, compare in the cycle after
      vcst_pkg::S_SCAN: begin
        if (!scan_step || cmp_match || (cmp_pend && (cmp_idx == SLOT_LAST))) begin
          state_next = vcst_pkg::S_EXEC;
        end else begin
          scan_issue = (scan_idx < SLOT_CNT);
          meta_re    = scan_issue;
        end
      end

      vcst_pkg::S_EXEC: begin
        if (!hit) begin
          if (out_free) begin
            emit       = 1'b1;
            state_next = vcst_pkg::S_IDLE;
            if ((op_func != vcst_pkg::FN_CREATE) || (op_id == vcst_pkg::NO_ID)) begin
              e_status = vcst_pkg::STAT_NOT_FOUND;
            end else if (free_ok) begin
              e_slot    = free_idx;
              meta_we   = 1'b1;
              live_set  = 1'b1;
              count_upd = 1'b1;
              count_val = live_count + CNT_W'(1);
              e_count   = count_val;
            end else begin
              e_status = vcst_pkg::STAT_NO_SPACE;
            end
          end
        end else if (revoke_walk || (op_func == vcst_pkg::FN_ALLOC)) begin
          walk_start = 1'b1;
          state_next = vcst_pkg::S_WALK;
        end else if (out_free) begin
          emit       = 1'b1;
          e_slot     = hit_idx;
          state_next = vcst_pkg::S_IDLE;
          if ((op_func == vcst_pkg::FN_CREATE) || (op_func == vcst_pkg::FN_FIND)) begin
            e_status = vcst_pkg::STAT_OK;
          end else if (!sel_ok) begin
            e_status = vcst_pkg::STAT_BAD_SEL;
          end else if (op_func == vcst_pkg::FN_BIND) begin
            sel_we    = 1'b1;
            sel_waddr = {hit_idx, op_sel[SEL_W-1:0]};
            sel_wdata = op_cap;
          end else if (op_func == vcst_pkg::FN_UNBIND) begin
            sel_we    = 1'b1;
            sel_waddr = {hit_idx, op_sel[SEL_W-1:0]};
          end else begin
            // lookup: read the entry, answer from S_LOOK
            emit       = 1'b0;
            sel_re     = 1'b1;
            sel_raddr  = {hit_idx, op_sel[SEL_W-1:0]};
            state_next = vcst_pkg::S_LOOK;
          end
        end
      end

      vcst_pkg::S_LOOK: begin
        if (out_free) begin
          emit       = 1'b1;
          e_slot     = hit_idx;
          e_cap      = (sel_rdata == vcst_pkg::SEL_RESERVED) ? '0 : sel_rdata;
          state_next = vcst_pkg::S_IDLE;
        end
      end

      // walk selectors: issue read of walk_sel, judge wcmp_sel
      vcst_pkg::S_WALK: begin
        if (!(wcmp_pend && (revoke_walk ? sel_nz : !sel_nz) && !out_free)) begin
          walk_adv   = 1'b1;
          walk_issue = (walk_sel < SEL_CNT);
          sel_re     = walk_issue;
          if (wcmp_pend) begin
            if (revoke_walk) begin
              if (sel_nz) begin
                emit     = 1'b1;
                e_slot   = hit_idx;
                e_sel    = wcmp_sel;
                e_cap    = sel_rdata;
                e_revoke = 1'b1;
                e_last   = 1'b0;
                e_count  = count_after;
                sel_we   = 1'b1;
              end
              if (wcmp_sel == SEL_LAST) begin
                state_next = vcst_pkg::S_FINAL;
              end
            end else if (!sel_nz) begin
              emit       = 1'b1;
              e_slot     = hit_idx;
              e_sel      = wcmp_sel;
              sel_we     = 1'b1;
              sel_wdata  = vcst_pkg::SEL_RESERVED;
              state_next = vcst_pkg::S_IDLE;
            end else if (wcmp_sel == SEL_LAST) begin
              state_next = vcst_pkg::S_FINAL;
            end
          end
        end
      end

      vcst_pkg::S_FINAL: begin
        if (out_free) begin
          emit       = 1'b1;
          e_slot     = hit_idx;
          state_next = vcst_pkg::S_IDLE;
          if (op_func == vcst_pkg::FN_ALLOC) begin
            e_status = vcst_pkg::STAT_NO_SPACE;
          end else begin
            e_count = count_after;
            if (op_func == vcst_pkg::FN_DESTROY) begin
              live_clr  = 1'b1;
              count_upd = 1'b1;
              count_val = count_dec;
            end
          end
        end
      end

      default: begin
        state_next = vcst_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vcst_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // registry flags, count, sweep address, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_live  <= '0;
      live_count <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == vcst_pkg::S_INIT) begin
        clr_addr <= clr_addr + SA_W'(1);
      end
      if (live_set) begin
        slot_live[free_idx] <= 1'b1;
      end
      if (live_clr) begin
        slot_live[hit_idx] <= 1'b0;
      end
      if (count_upd) begin
        live_count <= count_val;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // operation capture, scan and walk datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= vcst_pkg::func_t'(req.func);
      op_id    <= req.vpe_id;
      op_kid   <= req.kernel_id;
      op_kind  <= req.vpe_kind;
      op_sel   <= req.selector;
      op_cap   <= req.cap_value;
      scan_idx <= '0;
      cmp_pend <= 1'b0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
    end
    if (scan_step) begin
      scan_idx <= scan_idx + (SLOT_W+1)'(scan_issue);
      cmp_pend <= scan_issue;
      cmp_idx  <= scan_idx[SLOT_W-1:0];
      if (cmp_match) begin
        hit     <= 1'b1;
        hit_idx <= cmp_idx;
      end
      if (cmp_pend && !slot_live[cmp_idx] && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
    if (walk_start) begin
      walk_sel  <= (op_func == vcst_pkg::FN_ALLOC) ? (SEL_W+1)'(1) : '0;
      wcmp_pend <= 1'b0;
    end
    if (walk_adv) begin
      walk_sel  <= walk_sel + (SEL_W+1)'(walk_issue);
      wcmp_pend <= walk_issue;
      wcmp_sel  <= walk_sel[SEL_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= e_status;
      out_slot   <= vcst_pkg::SLOTO_W'(e_slot);
      out_sel    <= vcst_pkg::SELO_W'(e_sel);
      out_cap    <= e_cap;
      out_revoke <= e_revoke;
      out_count  <= vcst_pkg::COUNT_W'(e_count);
      out_last   <= e_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.slot_index   = out_slot;
  assign rsp.selector_out = out_sel;
  assign rsp.cap_out      = out_cap;
  assign rsp.revoke       = out_revoke;
  assign rsp.vpe_count    = out_count;
  assign rsp.last         = out_last;

endmodule

// ----- hw/rtl/vcst_checker.sv -----
// ----------------------------------------------------------------------------
// vcst_checker - port-level checks for the VPE capability selector table
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`include "vpe_capability_selector_table_core_macros.svh"

module vcst_checker #(
  parameter int VPE_SLOTS = vcst_pkg::DEF_VPE_SLOTS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [vcst_pkg::STATUS_W-1:0] rsp_status,
  input logic [vcst_pkg::SLOTO_W-1:0]  rsp_slot_index,
  input logic [vcst_pkg::SELO_W-1:0]   rsp_selector_out,
  input logic [vcst_pkg::CAP_W-1:0]    rsp_cap_out,
  input logic                          rsp_revoke,
  input logic [vcst_pkg::COUNT_W-1:0]  rsp_vpe_count,
  input logic                          rsp_last
);

  // a stalled result beat stays valid and keeps status, slot, selector, cap and last
  `VCST_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index) && $stable(rsp_selector_out) && $stable(rsp_cap_out) && $stable(rsp_last), "result beat changed while stalled")

  // one operation at a time: busy right after an accepted beat
  `VCST_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "request accepted while an operation is in flight")

  // revoke beats are not final and carry ok and a nonzero capability
  `VCST_ASSERT_SAME(a_revoke_not_last, clk, rst, rsp_valid && rsp_revoke, !rsp_last && (rsp_status == vcst_pkg::STAT_OK) && (rsp_cap_out != '0), "bad revoke beat")

  // error results are single, final and carry no capability
  `VCST_ASSERT_SAME(a_error_final, clk, rst, rsp_valid && (rsp_status != vcst_pkg::STAT_OK), rsp_last && !rsp_revoke && (rsp_cap_out == '0), "error result not final")

  // live count bounded by the slot count
  `VCST_ASSERT_SAME(a_count_bound, clk, rst, rsp_valid, rsp_vpe_count <= VPE_SLOTS, "live count above slot count")

endmodule

bind vpe_capability_selector_table_core vcst_checker #(.VPE_SLOTS(VPE_SLOTS)) u_vcst_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_slot_index   (rsp.slot_index),
  .rsp_selector_out (rsp.selector_out),
  .rsp_cap_out      (rsp.cap_out),
  .rsp_revoke       (rsp.revoke),
  .rsp_vpe_count    (rsp.vpe_count),
  .rsp_last         (rsp.last)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - VPE capability selector table testbench
// Drives operation beats from a prebuilt queue, predicts every result beat
// with a local table model and checks the response channel in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS          = vcst_pkg::DEF_VPE_SLOTS;
  localparam int SELS           = vcst_pkg::DEF_SELECTORS_PER_VPE;
  localparam int RANDOM_OPS     = 260;
  localparam int CALM_TAIL      = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 60;

  // one operation beat
  typedef struct {
    vcst_pkg::func_t func;
    logic [15:0] vpe_id;
    logic [15:0] kernel_id;
    logic [1:0]  vpe_kind;
    logic [7:0]  selector;
    logic [63:0] cap_value;
    bit          drain;       // hold off until all results are back
  } op_t;

  // one result beat
  typedef struct {
    vcst_pkg::status_t status;
    logic [2:0]  slot_index;
    logic [5:0]  selector_out;
    logic [63:0] cap_out;
    logic        revoke;
    logic [3:0]  vpe_count;
    logic        last;
  } result_t;

  logic clk;
  logic rst;

  vcst_req_if req_ch ();
  vcst_rsp_if rsp_ch ();

  vpe_capability_selector_table_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the registry
  bit          shadow_live [SLOTS];
  logic [15:0] shadow_id   [SLOTS];
  logic [63:0] shadow_sel  [SLOTS][SELS];
  logic [3:0]  shadow_count;

  op_t         op_backlog[$];
  result_t     predicted_results[$];
  op_t         cur_op;
  logic [15:0] id_pool [10];
  int          mismatches;
  int          send_gap;
  int          rsp_stall;
  int          quiet_cycles;
  logic [5:0]  window_cnt;
  logic        idle_en;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // table model
  // --------------------------------------------------------------------------
  function automatic int find_vpe(logic [15:0] id);
    if (id == vcst_pkg::NO_ID) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (shadow_live[i] && shadow_id[i] == id) return i;
    return -1;
  endfunction

  function automatic result_t make_beat(vcst_pkg::status_t st, int slot, int sel,
                                        logic [63:0] cap, int rev, int fin);
    result_t r;
    r.status       = st;
    r.slot_index   = slot[2:0];
    r.selector_out = sel[5:0];
    r.cap_out      = cap;
    r.revoke       = rev[0];
    r.vpe_count    = shadow_count;
    r.last         = fin[0];
    return r;
  endfunction

  task automatic predict_table_op(input op_t op);
    int  slot;
    int  free_slot;
    bit  done;
    logic [63:0] v;
    slot = find_vpe(op.vpe_id);
    if (op.func == vcst_pkg::FN_CREATE) begin
      if (slot >= 0) begin
        predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, slot, 0, '0, 0, 1));
      end else if (op.vpe_id == vcst_pkg::NO_ID) begin
        predicted_results.push_back(make_beat(vcst_pkg::STAT_NOT_FOUND, 0, 0, '0, 0, 1));
      end else begin
        free_slot = -1;
        for (int s = 0; s < SLOTS; s++)
          if (!shadow_live[s] && free_slot < 0) free_slot = s;
        if (free_slot < 0) begin
          predicted_results.push_back(make_beat(vcst_pkg::STAT_NO_SPACE, 0, 0, '0, 0, 1));
        end else begin
          shadow_live[free_slot] = 1'b1;
          shadow_id[free_slot]   = op.vpe_id;
          for (int s = 0; s < SELS; s++) shadow_sel[free_slot][s] = '0;
          shadow_count++;
          predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, free_slot, 0, '0, 0, 1));
        end
      end
      return;
    end
    // every other operation needs a live VPE
    if (slot < 0) begin
      predicted_results.push_back(make_beat(vcst_pkg::STAT_NOT_FOUND, 0, 0, '0, 0, 1));
      return;
    end
    case (op.func)
      vcst_pkg::FN_FIND: begin
        predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, slot, 0, '0, 0, 1));
      end
      vcst_pkg::FN_DESTROY, vcst_pkg::FN_CLEAR: begin
        // destroy drops the count before any revoke beat goes out
        if (op.func == vcst_pkg::FN_DESTROY) begin
          shadow_live[slot] = 1'b0;
          if (shadow_count != 0) shadow_count--;
        end
        for (int s = 0; s < SELS; s++) begin
          if (shadow_sel[slot][s] != '0) begin
            predicted_results.push_back(
              make_beat(vcst_pkg::STAT_OK, slot, s, shadow_sel[slot][s], 1, 0));
            shadow_sel[slot][s] = '0;
          end
        end
        predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, slot, 0, '0, 0, 1));
      end
      vcst_pkg::FN_BIND, vcst_pkg::FN_LOOKUP, vcst_pkg::FN_UNBIND: begin
        if (op.selector >= SELS) begin
          predicted_results.push_back(make_beat(vcst_pkg::STAT_BAD_SEL, slot, 0, '0, 0, 1));
        end else if (op.func == vcst_pkg::FN_BIND) begin
          shadow_sel[slot][op.selector] = op.cap_value;
          predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, slot, 0, '0, 0, 1));
        end else if (op.func == vcst_pkg::FN_LOOKUP) begin
          v = shadow_sel[slot][op.selector];
          if (v == vcst_pkg::SEL_RESERVED) v = '0;
          predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, slot, 0, v, 0, 1));
        end else begin
          shadow_sel[slot][op.selector] = '0;
          predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, slot, 0, '0, 0, 1));
        end
      end
      default: begin
        // alloc: first empty entry from index 1
        done = 1'b0;
        for (int s = 1; s < SELS; s++) begin
          if (!done && shadow_sel[slot][s] == '0) begin
            shadow_sel[slot][s] = vcst_pkg::SEL_RESERVED;
            predicted_results.push_back(make_beat(vcst_pkg::STAT_OK, slot, s, '0, 0, 1));
            done = 1'b1;
          end
        end
        if (!done)
          predicted_results.push_back(make_beat(vcst_pkg::STAT_NO_SPACE, slot, 0, '0, 0, 1));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_cap();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return vcst_pkg::SEL_RESERVED;
    return {$urandom(), $urandom()};
  endfunction

  function automatic op_t make_op(vcst_pkg::func_t f, logic [15:0] id, int sel,
                                  logic [63:0] cap);
    op_t op;
    op.func      = f;
    op.vpe_id    = id;
    op.kernel_id = 16'($urandom_range(0, 16'hFFFF));
    op.vpe_kind  = 2'($urandom_range(0, 3));
    op.selector  = sel[7:0];
    op.cap_value = cap;
    op.drain     = 1'b0;
    return op;
  endfunction

  function automatic logic [15:0] pick_id();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return vcst_pkg::NO_ID;
    if (pick == 1) return 16'($urandom_range(0, 16'hFFFF));
    return id_pool[$urandom_range(0, 9)];
  endfunction

  function automatic int pick_sel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(SELS, 255);
    return $urandom_range(0, SELS - 1);
  endfunction

  function automatic vcst_pkg::func_t pick_func();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 4)  return vcst_pkg::FN_CREATE;
    if (pick < 5)  return vcst_pkg::FN_FIND;
    if (pick < 6)  return vcst_pkg::FN_DESTROY;
    if (pick < 7)  return vcst_pkg::FN_CLEAR;
    if (pick < 11) return vcst_pkg::FN_BIND;
    if (pick < 14) return vcst_pkg::FN_LOOKUP;
    if (pick < 16) return vcst_pkg::FN_UNBIND;
    return vcst_pkg::FN_ALLOC;
  endfunction

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap     <= 0;
      idle_en      <= 1'b0;
      window_cnt   <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_table_op(cur_op);
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (op_backlog.size() != 0 &&
                     !(op_backlog[0].drain && predicted_results.size() != 0)) begin
          cur_op = op_backlog.pop_front();
          req_ch.func      <= cur_op.func;
          req_ch.vpe_id    <= cur_op.vpe_id;
          req_ch.kernel_id <= cur_op.kernel_id;
          req_ch.vpe_kind  <= cur_op.vpe_kind;
          req_ch.selector  <= cur_op.selector;
          req_ch.cap_value <= cur_op.cap_value;
          req_ch.valid     <= 1'b1;
          if (idle_en && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 7);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      // idling comes and goes in windows; none near the end
      window_cnt <= window_cnt + 1'b1;
      if (op_backlog.size() < CALM_TAIL) idle_en <= 1'b0;
      else if (window_cnt == '0) idle_en <= ($urandom_range(0, 3) != 0);
    end
  end

  // --------------------------------------------------------------------------
  // response monitor and checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (predicted_results.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, actual status %0d cap 0x%0h",
               $time, rsp_ch.status, rsp_ch.cap_out);
      mismatches++;
    end else begin
      want = predicted_results.pop_front();
      check_field("status",       64'(want.status),       64'(rsp_ch.status));
      check_field("slot_index",   64'(want.slot_index),   64'(rsp_ch.slot_index));
      check_field("selector_out", 64'(want.selector_out), 64'(rsp_ch.selector_out));
      check_field("cap_out",      want.cap_out,           rsp_ch.cap_out);
      check_field("revoke",       64'(want.revoke),       64'(rsp_ch.revoke));
      check_field("vpe_count",    64'(want.vpe_count),    64'(rsp_ch.vpe_count));
      check_field("last",         64'(want.last),         64'(rsp_ch.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      if (!idle_en) begin
        rsp_stall    <= 0;
        rsp_ch.ready <= 1'b1;
      end else if (rsp_stall != 0) begin
        rsp_stall    <= rsp_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        rsp_stall    <= $urandom_range(0, 6);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("[vpe_capability_selector_table_core] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int   n_ops;
    int   fill_len;
    int   pick;
    logic [15:0] id;
    op_t  op;

    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.func      = vcst_pkg::FN_CREATE;
    req_ch.vpe_id    = '0;
    req_ch.kernel_id = '0;
    req_ch.vpe_kind  = '0;
    req_ch.selector  = '0;
    req_ch.cap_value = '0;
    rsp_ch.ready     = 1'b0;
    mismatches       = 0;
    quiet_cycles     = 0;
    shadow_count     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_live[i] = 1'b0;
      shadow_id[i]   = '0;
      for (int s = 0; s < SELS; s++) shadow_sel[i][s] = '0;
    end

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFE;
    for (int i = 2; i < 10; i++) id_pool[i] = 16'($urandom_range(1, 16'hFFFD));

    // directed: extremes and each special case
    op = make_op(vcst_pkg::FN_CREATE, 16'h0000, 0, '0);
    op.kernel_id = 16'hFFFF;
    op.vpe_kind  = 2'd3;
    op_backlog.push_back(op);
    op_backlog.push_back(make_op(vcst_pkg::FN_CREATE, 16'h0000, 0, '0));   // already there
    op_backlog.push_back(make_op(vcst_pkg::FN_CREATE, vcst_pkg::NO_ID, 0, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_FIND,   16'h0000, 0, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_FIND,   16'h1234, 0, '0));   // unknown
    op_backlog.push_back(make_op(vcst_pkg::FN_BIND,   16'h0000, 0, vcst_pkg::SEL_RESERVED));
    op_backlog.push_back(make_op(vcst_pkg::FN_BIND,   16'h0000, SELS - 1,
                                 64'h8000_0000_0000_0001));
    op_backlog.push_back(make_op(vcst_pkg::FN_BIND,   16'h0000, SELS, 64'h1));  // out of range
    op_backlog.push_back(make_op(vcst_pkg::FN_LOOKUP, 16'h0000, 0, '0));   // reserved reads 0
    op_backlog.push_back(make_op(vcst_pkg::FN_LOOKUP, 16'h0000, SELS - 1, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_LOOKUP, 16'h0000, 255, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_ALLOC,  16'h0000, 0, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_UNBIND, 16'h0000, SELS - 1, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_BIND,   16'h0000, 5, '0));   // bind of empty
    op_backlog.push_back(make_op(vcst_pkg::FN_LOOKUP, vcst_pkg::NO_ID, 0, '0));
    op = make_op(vcst_pkg::FN_CREATE, 16'hFFFE, 0, '0);
    op.kernel_id = 16'h0000;
    op.vpe_kind  = 2'd0;
    op_backlog.push_back(op);
    op_backlog.push_back(make_op(vcst_pkg::FN_CLEAR,   16'h0000, 0, '0));  // revokes reserved
    op_backlog.push_back(make_op(vcst_pkg::FN_DESTROY, 16'h0000, 0, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_DESTROY, 16'h0000, 0, '0));  // now unknown
    op_backlog.push_back(make_op(vcst_pkg::FN_UNBIND,  16'hFFFE, 200, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_ALLOC,   16'h4321, 0, '0));
    op_backlog.push_back(make_op(vcst_pkg::FN_CLEAR,   16'hFFFE, 0, '0));  // nothing to revoke
    op_backlog.push_back(make_op(vcst_pkg::FN_DESTROY, 16'hFFFE, 0, '0));

    // random: fill sequences on one VPE mixed with loose operations
    n_ops = 0;
    while (n_ops < RANDOM_OPS) begin
      if ($urandom_range(0, 11) == 0) begin
        id = id_pool[$urandom_range(0, 9)];
        op_backlog.push_back(make_op(vcst_pkg::FN_CREATE, id, 0, '0));
        fill_len = $urandom_range(20, 36);
        for (int i = 0; i < fill_len; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 6)
            op_backlog.push_back(make_op(vcst_pkg::FN_ALLOC, id, 0, '0));
          else if (pick < 8)
            op_backlog.push_back(make_op(vcst_pkg::FN_BIND, id, pick_sel(), rand_cap()));
          else
            op_backlog.push_back(make_op(vcst_pkg::FN_LOOKUP, id, pick_sel(), '0));
        end
        op_backlog.push_back(make_op($urandom_range(0, 1) ? vcst_pkg::FN_CLEAR
                                                          : vcst_pkg::FN_DESTROY,
                                     id, 0, '0));
        n_ops += fill_len + 2;
      end else begin
        op = make_op(pick_func(), pick_id(), pick_sel(), rand_cap());
        if (n_ops == 0 || $urandom_range(0, 49) == 0) op.drain = 1'b1;
        op_backlog.push_back(op);
        n_ops++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0 || req_ch.valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && predicted_results.size() == 0)
      $display("[vpe_capability_selector_table_core] OK");
    else
      $display("[vpe_capability_selector_table_core] ERROR");
    $finish;
  end

endmodule
